>>> sv/bbl_pkg.sv
package bbl_pkg;

  // table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int KEY_W   = 32;
  localparam int BYTES_W = 27;
  localparam int USED_W  = 32;
  localparam int STAMP_W = 64;
  localparam int KIND_W  = 2;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic [USED_W-1:0] BUDGET_RESET = 32'd25165824;
  localparam logic [ADDR_W-3:0] REG_BUDGET   = 1'b0;

  // input action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_EVICT  = 2'd1,
    KIND_STORE  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SCAN   = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_DROP   = 3'd4,
    OP_REJECT = 3'd5,
    OP_EVICT  = 3'd6,
    OP_STORE  = 3'd7
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;
    logic is_insert;
    logic match;
    logic oversize;
    logic need_evict;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> sv/bbl_ifs.sv
interface bbl_in_if;
  import bbl_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [KEY_W-1:0]   key;
  logic [BYTES_W-1:0] item_bytes;

  modport source (output valid, action, key, item_bytes, input ready);
  modport sink   (input valid, action, key, item_bytes, output ready);
endinterface

interface bbl_out_if;
  import bbl_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   result_key;
  logic [BYTES_W-1:0] result_bytes;
  logic               hit;
  logic [USED_W-1:0]  used_bytes;
  logic               last;

  modport source (output valid, kind, result_key, result_bytes, hit, used_bytes, last,
                  input ready);
  modport sink   (input valid, kind, result_key, result_bytes, hit, used_bytes, last,
                  output ready);
endinterface

>>> sv/bbl_ctrl.sv
module bbl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbl_pkg::ctl_sts_t sts,
  output bbl_pkg::ctl_cmd_t cmd
);
  import bbl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_LOOKUP = 4'd2;
  localparam logic [3:0] S_DROP   = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_REJECT = 4'd5;
  localparam logic [3:0] S_EVAL   = 4'd6;
  localparam logic [3:0] S_ESCAN  = 4'd7;
  localparam logic [3:0] S_EVICT  = 4'd8;
  localparam logic [3:0] S_STORE  = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.busy) begin
          if (!sts.is_insert) state_nxt = S_LOOKUP;
          else if (sts.match) state_nxt = S_DROP;
          else                state_nxt = S_CHECK;
        end
      end
      S_LOOKUP: begin
        if (sts.out_free) begin
          cmd.op    = OP_LOOKUP;
          state_nxt = S_IDLE;
        end
      end
      S_DROP: begin
        cmd.op    = OP_DROP;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.oversize ? S_REJECT : S_EVAL;
      end
      S_REJECT: begin
        if (sts.out_free) begin
          cmd.op    = OP_REJECT;
          state_nxt = S_IDLE;
        end
      end
      S_EVAL: begin
        if (sts.need_evict) begin
          cmd.op    = OP_SCAN;
          state_nxt = S_ESCAN;
        end else begin
          state_nxt = S_STORE;
        end
      end
      S_ESCAN: begin
        if (!sts.busy) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        if (sts.out_free) begin
          cmd.op    = OP_EVICT;
          state_nxt = S_EVAL;
        end
      end
      S_STORE: begin
        if (sts.out_free) begin
          cmd.op    = OP_STORE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/bbl_dpath.sv
module bbl_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bbl_pkg::ctl_cmd_t            cmd,
  output bbl_pkg::ctl_sts_t            sts,
  input  logic                         in_action,
  input  logic [bbl_pkg::KEY_W-1:0]    in_key,
  input  logic [bbl_pkg::BYTES_W-1:0]  in_item_bytes,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bbl_pkg::KIND_W-1:0]   out_kind,
  output logic [bbl_pkg::KEY_W-1:0]    out_result_key,
  output logic [bbl_pkg::BYTES_W-1:0]  out_result_bytes,
  output logic                         out_hit,
  output logic [bbl_pkg::USED_W-1:0]   out_used_bytes,
  output logic                         out_last,
  input  logic                         cfg_wr,
  input  logic [bbl_pkg::DATA_W-1:0]   cfg_wdata,
  output logic [bbl_pkg::DATA_W-1:0]   cfg_budget
);
  import bbl_pkg::*;

  // slot storage
  logic [KEY_W-1:0]   mem_key   [ENTRIES];
  logic [BYTES_W-1:0] mem_bytes [ENTRIES];
  logic [STAMP_W-1:0] mem_stamp [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   vcnt_r;

  // counters and configuration
  logic [USED_W-1:0]  total_r;
  logic [STAMP_W-1:0] count_r;
  logic [USED_W-1:0]  budget_r;

  // latched transaction
  logic               act_r;
  logic [KEY_W-1:0]   key_r;
  logic [BYTES_W-1:0] bytes_r;

  // scan engine
  logic               scan_busy_r;
  logic               rd_pend_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [KEY_W-1:0]   rd_key_r;
  logic [BYTES_W-1:0] rd_bytes_r;
  logic [STAMP_W-1:0] rd_stamp_r;

  logic               match_found_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic [BYTES_W-1:0] match_bytes_r;
  logic               best_found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [KEY_W-1:0]   best_key_r;
  logic [BYTES_W-1:0] best_bytes_r;
  logic [STAMP_W-1:0] best_stamp_r;

  // result register
  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [KEY_W-1:0]   res_key_r;
  logic [BYTES_W-1:0] res_bytes_r;
  logic               hit_r;
  logic [USED_W-1:0]  used_r;
  logic               last_r;

  logic [IDX_W-1:0]   free_idx;
  logic [STAMP_W-1:0] count_inc;
  logic [USED_W-1:0]  total_evict;
  logic [USED_W-1:0]  total_drop;
  logic [USED_W-1:0]  total_store;
  logic               over;
  logic               emit;
  logic               start_scan;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IDX_W'(i);
    end
  end

  assign count_inc   = count_r + STAMP_W'(1);
  assign total_evict = total_r - USED_W'(best_bytes_r);
  assign total_drop  = total_r - USED_W'(match_bytes_r);
  assign total_store = total_r + USED_W'(bytes_r);
  assign over        = ({1'b0, total_r} + (USED_W + 1)'(bytes_r)) > {1'b0, budget_r};
  assign start_scan  = (cmd.op == OP_LOAD) || (cmd.op == OP_SCAN);
  assign emit        = (cmd.op == OP_LOOKUP) || (cmd.op == OP_REJECT) ||
                       (cmd.op == OP_EVICT) || (cmd.op == OP_STORE);

  // status to controller
  assign sts.busy       = scan_busy_r | rd_pend_r;
  assign sts.is_insert  = (act_r == ACT_INSERT);
  assign sts.match      = match_found_r;
  assign sts.oversize   = USED_W'(bytes_r) > budget_r;
  assign sts.need_evict = (over && (vcnt_r != '0)) || (vcnt_r == CNT_W'(ENTRIES));
  assign sts.out_free   = !out_valid_r || out_ready;

  // slot memory: one read port at the scan index, one write port
  always_ff @(posedge clk) begin
    rd_key_r   <= mem_key[scan_idx_r];
    rd_bytes_r <= mem_bytes[scan_idx_r];
    rd_stamp_r <= mem_stamp[scan_idx_r];
    rd_idx_r   <= scan_idx_r;
    if (cmd.op == OP_STORE) begin
      mem_key[free_idx]   <= key_r;
      mem_bytes[free_idx] <= bytes_r;
      mem_stamp[free_idx] <= count_inc;
    end else if (cmd.op == OP_LOOKUP && match_found_r) begin
      mem_stamp[match_idx_r] <= count_inc;
    end
  end

  // control state, scan sequencing and table bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_busy_r   <= 1'b0;
      rd_pend_r     <= 1'b0;
      scan_idx_r    <= '0;
      match_found_r <= 1'b0;
      best_found_r  <= 1'b0;
      valid_r       <= '0;
      vcnt_r        <= '0;
      total_r       <= '0;
      count_r       <= '0;
      budget_r      <= BUDGET_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) budget_r <= cfg_wdata;

      // walk the slots one per cycle
      rd_pend_r <= scan_busy_r;
      if (start_scan) begin
        scan_busy_r   <= 1'b1;
        scan_idx_r    <= '0;
        match_found_r <= 1'b0;
        best_found_r  <= 1'b0;
      end else if (scan_busy_r) begin
        if (scan_idx_r == IDX_W'(ENTRIES - 1)) scan_busy_r <= 1'b0;
        else                                   scan_idx_r  <= scan_idx_r + 1'b1;
      end

      // first key match and oldest stamp, ties to the lowest slot
      if (rd_pend_r && valid_r[rd_idx_r]) begin
        if (!match_found_r && rd_key_r == key_r) begin
          match_found_r <= 1'b1;
          match_idx_r   <= rd_idx_r;
          match_bytes_r <= rd_bytes_r;
        end
        if (!best_found_r || rd_stamp_r < best_stamp_r) begin
          best_found_r <= 1'b1;
          best_idx_r   <= rd_idx_r;
          best_key_r   <= rd_key_r;
          best_bytes_r <= rd_bytes_r;
          best_stamp_r <= rd_stamp_r;
        end
      end

      case (cmd.op)
        OP_LOOKUP: begin
          if (match_found_r) count_r <= count_inc;
        end
        OP_DROP: begin
          valid_r[match_idx_r] <= 1'b0;
          total_r              <= total_drop;
          vcnt_r               <= vcnt_r - 1'b1;
        end
        OP_EVICT: begin
          valid_r[best_idx_r] <= 1'b0;
          total_r             <= total_evict;
          vcnt_r              <= vcnt_r - 1'b1;
        end
        OP_STORE: begin
          valid_r[free_idx] <= 1'b1;
          total_r           <= total_store;
          vcnt_r            <= vcnt_r + 1'b1;
          count_r           <= count_inc;
        end
        default: ;
      endcase

      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // transaction latch and result payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      act_r   <= in_action;
      key_r   <= in_key;
      bytes_r <= in_item_bytes;
    end
    case (cmd.op)
      OP_LOOKUP: begin
        kind_r      <= KIND_LOOKUP;
        res_key_r   <= key_r;
        res_bytes_r <= match_found_r ? match_bytes_r : '0;
        hit_r       <= match_found_r;
        used_r      <= total_r;
        last_r      <= 1'b1;
      end
      OP_REJECT: begin
        kind_r      <= KIND_REJECT;
        res_key_r   <= key_r;
        res_bytes_r <= '0;
        hit_r       <= 1'b0;
        used_r      <= total_r;
        last_r      <= 1'b1;
      end
      OP_EVICT: begin
        kind_r      <= KIND_EVICT;
        res_key_r   <= best_key_r;
        res_bytes_r <= best_bytes_r;
        hit_r       <= 1'b0;
        used_r      <= total_evict;
        last_r      <= 1'b0;
      end
      OP_STORE: begin
        kind_r      <= KIND_STORE;
        res_key_r   <= key_r;
        res_bytes_r <= '0;
        hit_r       <= 1'b0;
        used_r      <= total_store;
        last_r      <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_result_key   = res_key_r;
  assign out_result_bytes = res_bytes_r;
  assign out_hit          = hit_r;
  assign out_used_bytes   = used_r;
  assign out_last         = last_r;
  assign cfg_budget       = budget_r;

`ifndef SYNTHESIS
  // fill count tracks the valid bits
  a_vcnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(vcnt_r))
    else $error("valid count out of step with valid bits");

  // an eviction always has a live victim
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EVICT) |-> (best_found_r && valid_r[best_idx_r]))
    else $error("eviction without a valid oldest entry");

  // a store always finds a free slot
  a_store: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_STORE) |-> (vcnt_r < CNT_W'(ENTRIES)))
    else $error("store into a full table");

  // a result is never loaded over one still waiting
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // a scan is never restarted while one is running
  a_scan: assert property (@(posedge clk) disable iff (!rst_n)
    start_scan |-> !(scan_busy_r || rd_pend_r))
    else $error("scan restarted while busy");
`endif

endmodule

>>> sv/byte_budget_lru_cache_top.sv
// channel   dir  handshake          payload
// in_chan   in   valid/ready        action, key, item_bytes
// out_chan  out  valid/ready        kind, result_key, result_bytes, hit, used_bytes, last
// cfg_*     in   apb write/read     budget_bytes at byte address 0
//
// every item starts with a scan of all slots, one slot per cycle through the single
// memory read port: a lookup result is loaded once that scan is done; an insert drops
// the old entry first when a key is replaced, then loads a reject, or an eviction
// result for each victim and then the store, where each victim search
// is a fresh pass over the slots
// the next item is accepted at the edge after the final result is loaded; a waiting
// result does not block that accept
// out_ready low holds the block at its next result; reset is synchronous, active low,
// empties the table and loads the 24 MiB budget
module byte_budget_lru_cache_top (
  input  logic                        clk,
  input  logic                        rst_n,
  bbl_in_if.sink                      in_chan,
  bbl_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bbl_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [bbl_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [bbl_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import bbl_pkg::*;

  ctl_cmd_t          cmd;
  ctl_sts_t          sts;
  logic              cfg_wr;
  logic              budget_sel;
  logic [DATA_W-1:0] budget;

  // register decode, one word per register
  assign budget_sel = (cfg_paddr[ADDR_W-1:2] == REG_BUDGET);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && budget_sel;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = budget_sel ? budget : '0;

  bbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbl_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_chan.action),
    .in_key           (in_chan.key),
    .in_item_bytes    (in_chan.item_bytes),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_kind         (out_chan.kind),
    .out_result_key   (out_chan.result_key),
    .out_result_bytes (out_chan.result_bytes),
    .out_hit          (out_chan.hit),
    .out_used_bytes   (out_chan.used_bytes),
    .out_last         (out_chan.last),
    .cfg_wr           (cfg_wr),
    .cfg_wdata        (cfg_pwdata),
    .cfg_budget       (budget)
  );

endmodule
